>>> hw/rtl/fptxt_pkg.sv
// Shared types, constants and helper functions for the float-to-decimal-text block.
// No dependencies; every other file of the block imports this package.
package fptxt_pkg;

  localparam int unsigned DIGIT_SLOTS_DEF = 44;
  localparam int unsigned LEN_W           = 6;
  localparam int unsigned ND_W            = 7;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] EXP_BIAS_M1 = 8'd126;
  localparam logic [7:0] EXP_BIAS    = 8'd127;
  localparam logic [7:0] EXP_MAX     = 8'hFF;

  typedef struct packed {
    logic [31:0] float_bits;
    logic [7:0]  capacity;
  } in_t;

  typedef struct packed {
    logic [7:0]       char_out;
    logic             written;
    logic             is_last;
    logic [LEN_W-1:0] full_length;
  } out_t;

  typedef enum logic [2:0] {
    CK_MINUS  = 3'd0,
    CK_DIGIT  = 3'd1,
    CK_LETTER = 3'd2,
    CK_DOT    = 3'd3,
    CK_ZERO   = 3'd4,
    CK_TERM   = 3'd5
  } char_kind_e;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             shift_up;
    logic             emit;
    char_kind_e       kind;
    logic [1:0]       letter_idx;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic            neg_eff;
    logic            word;
    logic [7:0]      steps;
    logic [7:0]      cap;
    logic [ND_W-1:0] nd;
    logic            top_sig;
    logic            out_free;
  } status_t;

  // Letters of the special words: "nan" for NaN, "inf" for infinity.
  function automatic logic [7:0] word_char(input logic is_nan, input logic [1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    if (is_nan) begin
      case (idx)
        2'd0:    c = 8'h6E;
        2'd1:    c = 8'h61;
        2'd2:    c = 8'h6E;
        default: c = 8'h00;
      endcase
    end else begin
      case (idx)
        2'd0:    c = 8'h69;
        2'd1:    c = 8'h6E;
        2'd2:    c = 8'h66;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/fptxt_dpath.sv
// Datapath: input capture, BCD digit register with double-dabble steps, output word register.
// Depends on fptxt_pkg.
module fptxt_dpath import fptxt_pkg::*; #(
  parameter int unsigned DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  in_t     in_data_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output out_t    out_data_o
);

  localparam int unsigned NDW = $clog2(DIGIT_SLOTS + 1);

  logic [3:0]       dig_q [DIGIT_SLOTS];
  logic [3:0]       dig_d [DIGIT_SLOTS];
  logic [3:0]       adj   [DIGIT_SLOTS];
  logic [DIGIT_SLOTS-1:0] sig_q, sig_d;
  logic [NDW-1:0]   nd_q, nd_d;
  logic [23:0]      mant_q, mant_d;
  logic             neg_eff_q, word_q, nan_q;
  logic [7:0]       steps_q, cap_q;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic [7:0]  in_exp;
  logic [22:0] in_frac;
  logic        in_max, in_nan;

  assign in_exp  = in_data_i.float_bits[30:23];
  assign in_frac = in_data_i.float_bits[22:0];
  assign in_max  = (in_exp == EXP_MAX);
  assign in_nan  = in_max && (in_frac != 23'd0);

  // Double-dabble: digits of five or more get three added before the shift.
  always_comb begin
    for (int k = 0; k < DIGIT_SLOTS; k++) begin
      adj[k] = (dig_q[k] >= 4'd5) ? dig_q[k] + 4'd3 : dig_q[k];
    end
  end

  always_comb begin
    dig_d  = dig_q;
    sig_d  = sig_q;
    nd_d   = nd_q;
    mant_d = mant_q;
    if (cmd_i.load) begin
      for (int k = 0; k < DIGIT_SLOTS; k++) begin
        dig_d[k] = 4'd0;
      end
      sig_d  = {{(DIGIT_SLOTS-1){1'b0}}, 1'b1};
      nd_d   = NDW'(1);
      mant_d = {1'b1, in_frac};
    end else if (cmd_i.step) begin
      dig_d[0] = {adj[0][2:0], mant_q[23]};
      for (int k = 1; k < DIGIT_SLOTS; k++) begin
        dig_d[k] = {adj[k][2:0], adj[k-1][3]};
        sig_d[k] = sig_q[k] | (sig_q[k-1] & adj[k-1][3]);
      end
      nd_d   = nd_q + NDW'(|(sig_d & ~sig_q));
      mant_d = {mant_q[22:0], 1'b0};
    end else if (cmd_i.shift_up) begin
      dig_d[0] = 4'd0;
      for (int k = 1; k < DIGIT_SLOTS; k++) begin
        dig_d[k] = dig_q[k-1];
      end
      sig_d = {sig_q[DIGIT_SLOTS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    sig_q  <= sig_d;
    nd_q   <= nd_d;
    mant_q <= mant_d;
    if (cmd_i.load) begin
      neg_eff_q <= in_data_i.float_bits[31] && !in_nan;
      word_q    <= in_max;
      nan_q     <= in_nan;
      steps_q   <= (!in_max && (in_exp >= EXP_BIAS)) ? in_exp - EXP_BIAS_M1 : 8'd0;
      cap_q     <= in_data_i.capacity;
    end
  end

  // Output word register.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit) begin
      out_valid_d       = 1'b1;
      out_d.written     = 1'b1;
      out_d.is_last     = 1'b0;
      out_d.full_length = '0;
      case (cmd_i.kind)
        CK_MINUS:  out_d.char_out = CH_MINUS;
        CK_DIGIT:  out_d.char_out = CH_ZERO + {4'd0, dig_q[DIGIT_SLOTS-1]};
        CK_LETTER: out_d.char_out = word_char(nan_q, cmd_i.letter_idx);
        CK_DOT:    out_d.char_out = CH_DOT;
        CK_ZERO:   out_d.char_out = CH_ZERO;
        CK_TERM: begin
          out_d.char_out    = 8'h00;
          out_d.written     = (cap_q != 8'd0);
          out_d.is_last     = 1'b1;
          out_d.full_length = cmd_i.len;
        end
        default:   out_d.char_out = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.neg_eff  = neg_eff_q;
  assign status_o.word     = word_q;
  assign status_o.steps    = steps_q;
  assign status_o.cap      = cap_q;
  assign status_o.nd       = ND_W'(nd_q);
  assign status_o.top_sig  = sig_q[DIGIT_SLOTS-1];
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

>>> hw/rtl/fptxt_ctrl.sv
// Controller: sequences load, conversion, alignment and character emission.
// Depends on fptxt_pkg; drives the datapath through cmd_t and reads status_t.
module fptxt_ctrl import fptxt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PREP  = 9'b000000010,
    S_CONV  = 9'b000000100,
    S_ALIGN = 9'b000001000,
    S_SIGN  = 9'b000010000,
    S_BODY  = 9'b000100000,
    S_DOT   = 9'b001000000,
    S_ZERO  = 9'b010000000,
    S_TERM  = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [LEN_W-1:0] emitted_q, emitted_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [7:0]       room;
  logic             can_emit;
  cmd_t             cmd;

  assign room     = (status_i.cap == 8'd0) ? 8'd0 : status_i.cap - 8'd1;
  assign can_emit = ({2'b00, emitted_q} < room);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    emitted_d = emitted_q;
    len_d     = len_q;
    cmd       = '0;
    cmd.kind  = CK_TERM;
    cmd.len   = len_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load  = 1'b1;
          emitted_d = '0;
          state_d   = S_PREP;
        end
      end
      S_PREP: begin
        cnt_d   = status_i.steps;
        state_d = S_CONV;
      end
      S_CONV: begin
        if (cnt_q != 8'd0) begin
          cmd.step = 1'b1;
          cnt_d    = cnt_q - 8'd1;
        end else begin
          len_d   = LEN_W'(status_i.neg_eff) +
                    (status_i.word ? LEN_W'(3) : LEN_W'(status_i.nd) + LEN_W'(2));
          cnt_d   = status_i.word ? 8'd3 : 8'(status_i.nd);
          state_d = status_i.word ? S_SIGN : S_ALIGN;
        end
      end
      S_ALIGN: begin
        if (status_i.top_sig) begin
          state_d = S_SIGN;
        end else begin
          cmd.shift_up = 1'b1;
        end
      end
      S_SIGN: begin
        if (!status_i.neg_eff) begin
          state_d = S_BODY;
        end else if (!can_emit) begin
          state_d = S_TERM;
        end else if (status_i.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = CK_MINUS;
          emitted_d = emitted_q + LEN_W'(1);
          state_d   = S_BODY;
        end
      end
      S_BODY: begin
        if (cnt_q == 8'd0) begin
          state_d = status_i.word ? S_TERM : S_DOT;
        end else if (!can_emit) begin
          state_d = S_TERM;
        end else if (status_i.out_free) begin
          cmd.emit       = 1'b1;
          cmd.kind       = status_i.word ? CK_LETTER : CK_DIGIT;
          cmd.letter_idx = 2'(8'd3 - cnt_q);
          cmd.shift_up   = !status_i.word;
          cnt_d          = cnt_q - 8'd1;
          emitted_d      = emitted_q + LEN_W'(1);
        end
      end
      S_DOT: begin
        if (!can_emit) begin
          state_d = S_TERM;
        end else if (status_i.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = CK_DOT;
          emitted_d = emitted_q + LEN_W'(1);
          state_d   = S_ZERO;
        end
      end
      S_ZERO: begin
        if (!can_emit) begin
          state_d = S_TERM;
        end else if (status_i.out_free) begin
          cmd.emit  = 1'b1;
          cmd.kind  = CK_ZERO;
          emitted_d = emitted_q + LEN_W'(1);
          state_d   = S_TERM;
        end
      end
      S_TERM: begin
        if (status_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = CK_TERM;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    emitted_q <= emitted_d;
    len_q     <= len_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

  // A character is only issued while the buffer still has room for it.
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && (cmd.kind != CK_TERM)) |-> can_emit)
    else $error("character issued beyond buffer room");

  // The datapath output register must be free whenever a word is issued.
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status_i.out_free)
    else $error("word issued into a busy output register");

  // While digits remain, the most significant one sits in the top slot.
  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_BODY) && !status_i.word && (cnt_q != 8'd0)) |-> status_i.top_sig)
    else $error("digit register lost alignment");

  // Truncation never emits more characters than the full text holds.
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TERM) |-> (emitted_q <= len_q))
    else $error("emitted count exceeds text length");

endmodule

>>> hw/rtl/float_integer_part_to_decimal_text.sv
// Conversion: a finite value with |x| >= 1 and unbiased exponent e takes e+1 conversion steps
// (up to 128); smaller values, inf and nan take none. A short buffer ends the text early.
// Throughput: one value at a time; a new value is accepted after the previous terminator is issued.
// Reset: rst_ni clears the controller state and the output valid flag asynchronously.
//
// The block prints the truncated integer part of an IEEE single as decimal text, one character
// per output word, followed by a terminator word that carries the untruncated text length.
// The integer part (mantissa shifted by the exponent, up to 128 bits) is converted exactly by
// double-dabble: the 24 mantissa bits are shifted MSB first into a BCD digit register, followed
// by zeros, one bit per cycle, for e+1 steps in total. The conversion loop over the shift count
// sets the cycle count of large values. A significance mask next to the digits tracks the digit
// count without scanning the register. After conversion the digits are shifted up until the
// most significant one sits in the top slot, and the text is then read from that slot while the
// register keeps shifting. Characters that do not fit the buffer (capacity minus one) are not
// sent; the terminator is always sent. The output register lets the last word of a value wait
// for the consumer while the controller moves on.
module float_integer_part_to_decimal_text import fptxt_pkg::*; #(
  parameter int unsigned DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencer for the conversion and the character stream.
  fptxt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Digit register, captured input fields and the output word register.
  fptxt_dpath #(
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
